[hdl/lextok_pkg.sv]
// lexical tokenizer package: token kinds, character codes, keyword tables, memory request type
package lextok_pkg;

    // default sizes
    localparam int MAX_LEXEME_DEF   = 32;
    localparam int SYMBOL_SLOTS_DEF = 64;

    // token kinds
    localparam logic [3:0] K_WHILE  = 4'd0;
    localparam logic [3:0] K_IF     = 4'd1;
    localparam logic [3:0] K_ELSE   = 4'd2;
    localparam logic [3:0] K_SWITCH = 4'd3;
    localparam logic [3:0] K_CASE   = 4'd4;
    localparam logic [3:0] K_IDENT  = 4'd5;
    localparam logic [3:0] K_NUMBER = 4'd6;
    localparam logic [3:0] K_PLUS   = 4'd7;
    localparam logic [3:0] K_MINUS  = 4'd8;
    localparam logic [3:0] K_STAR   = 4'd9;
    localparam logic [3:0] K_LT     = 4'd10;
    localparam logic [3:0] K_LE     = 4'd11;
    localparam logic [3:0] K_EQ     = 4'd12;
    localparam logic [3:0] K_ASSIGN = 4'd13;
    localparam logic [3:0] K_SEMI   = 4'd14;
    localparam logic [3:0] K_ERROR  = 4'd15;

    localparam int NUM_KEYWORDS = 5;

    // character codes
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;

    // lexeme buffer request from the scanner
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [7:0] wr_data;
    } mem_req_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // keyword lengths
    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] n;
        case (k)
            3'd0:    n = 3'd5;
            3'd1:    n = 3'd2;
            3'd2:    n = 3'd4;
            3'd3:    n = 3'd6;
            3'd4:    n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // keyword text, one character per position
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [5:0] pos);
        logic [7:0] ch;
        ch = 8'd0;
        case (k)
            3'd0: begin
                case (pos)
                    6'd0: ch = "w";
                    6'd1: ch = "h";
                    6'd2: ch = "i";
                    6'd3: ch = "l";
                    6'd4: ch = "e";
                    default: ch = 8'd0;
                endcase
            end
            3'd1: begin
                case (pos)
                    6'd0: ch = "i";
                    6'd1: ch = "f";
                    default: ch = 8'd0;
                endcase
            end
            3'd2: begin
                case (pos)
                    6'd0: ch = "e";
                    6'd1: ch = "l";
                    6'd2: ch = "s";
                    6'd3: ch = "e";
                    default: ch = 8'd0;
                endcase
            end
            3'd3: begin
                case (pos)
                    6'd0: ch = "s";
                    6'd1: ch = "w";
                    6'd2: ch = "i";
                    6'd3: ch = "t";
                    6'd4: ch = "c";
                    6'd5: ch = "h";
                    default: ch = 8'd0;
                endcase
            end
            3'd4: begin
                case (pos)
                    6'd0: ch = "c";
                    6'd1: ch = "a";
                    6'd2: ch = "s";
                    6'd3: ch = "e";
                    default: ch = 8'd0;
                endcase
            end
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

[hdl/lexical_tokenizer.sv]
// lexical tokenizer top level: scanner control and lexeme buffer
//
// Input channel s_*: one text byte per word in s_tdata[7:0]; s_tlast high
// marks end of text, which flushes any pending token (the byte is ignored).
// Result channel m_*: one word per token, or one word per lexeme byte for
// identifiers and numbers, with m_tlast on the final word of each token.
// m_tuser carries the kind and flags, m_tdata the byte and symbol slot.
// Sequencing: a byte that extends or starts a token is accepted and then
// evaluated. A byte that closes a keyword, '<' or '=' token is then
// rescanned. An identifier or number is replayed from the lexeme buffer,
// each stored byte by a read of the buffer memory and a load of the
// result register, before the closing byte is rescanned. The first result
// word is loaded when the closing byte is evaluated, or for an identifier
// or number at the first load of the replay.
// Reset (aresetn low, synchronous) empties the result register, returns the
// scanner to idle and restarts slot numbering at 0; no clearing pass.
// When the receiver stalls, the result register holds and the scanner waits;
// s_tready stays low until the current byte is fully handled.
module lexical_tokenizer #(
    parameter int MAX_LEXEME   = lextok_pkg::MAX_LEXEME_DEF,
    parameter int SYMBOL_SLOTS = lextok_pkg::SYMBOL_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] lexeme_byte, [13:8] symbol_index, [15:14] zero
    output logic        m_tlast,   // last_of_token
    output logic [5:0]  m_tuser    // [3:0] token_kind, [4] table_full, [5] truncated
);
    import lextok_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LEXEME);

    mem_req_t          req;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // scanner
    lextok_ctrl #(
        .MAX_LEXEME   (MAX_LEXEME),
        .SYMBOL_SLOTS (SYMBOL_SLOTS),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .req      (req),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // lexeme storage
    lextok_buf #(
        .DEPTH  (MAX_LEXEME),
        .ADDR_W (ADDR_W)
    ) u_buf (
        .aclk    (aclk),
        .req     (req),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

[hdl/lextok_buf.sv]
// lexeme buffer: single-port write, registered read
module lextok_buf #(
    parameter int DEPTH  = lextok_pkg::MAX_LEXEME_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  lextok_pkg::mem_req_t req,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [7:0]           rd_data
);
    import lextok_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[wr_addr] <= req.wr_data;
        end
    end

    // read port, registered, holds between reads
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/lextok_ctrl.sv]
// scanner control: character classing, keyword tracking, slot allocation, result register
module lextok_ctrl #(
    parameter int MAX_LEXEME   = lextok_pkg::MAX_LEXEME_DEF,
    parameter int SYMBOL_SLOTS = lextok_pkg::SYMBOL_SLOTS_DEF,
    parameter int ADDR_W       = $clog2(MAX_LEXEME)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,
    output logic                 m_tlast,
    output logic [5:0]           m_tuser,
    // lexeme buffer
    output lextok_pkg::mem_req_t req,
    output logic [ADDR_W-1:0]    wr_addr,
    output logic [ADDR_W-1:0]    rd_addr,
    input  logic [7:0]           rd_data
);
    import lextok_pkg::*;

    localparam int LEN_W  = $clog2(MAX_LEXEME + 1);
    localparam int SLOT_W = $clog2(SYMBOL_SLOTS);

    // sequencer states
    localparam logic [2:0] S_IN   = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_BYTE = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // scan modes
    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_IDENT  = 3'd1;
    localparam logic [2:0] M_NUMBER = 3'd2;
    localparam logic [2:0] M_LT     = 3'd3;
    localparam logic [2:0] M_EQ     = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [2:0]        mode_reg, mode_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [4:0]        kw_reg, kw_next;
    logic              ovf_reg, ovf_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              full_reg, full_next;
    logic [3:0]        rkind_reg, rkind_next;
    logic [7:0]        char_reg;
    logic              eot_reg;

    logic              m_valid_reg, m_valid_next;
    logic [3:0]        o_kind_reg;
    logic [7:0]        o_byte_reg;
    logic              o_last_reg;
    logic [SLOT_W-1:0] o_slot_reg;
    logic              o_full_reg;
    logic              o_trunc_reg;

    // emission into the result register
    logic              emit;
    logic [3:0]        e_kind;
    logic [7:0]        e_byte;
    logic              e_last;
    logic [SLOT_W-1:0] e_slot;
    logic              e_full;
    logic              e_trunc;

    logic              out_free;
    logic              accept;
    logic              byte_phase;
    logic              c_letter, c_digit, c_space;
    logic [5:0]        pos;
    logic [4:0]        kw_base, kw_step;
    logic [4:0]        kw_done;
    logic              kw_found;
    logic [3:0]        kw_kind;
    logic [LEN_W-1:0]  idx_plus;
    logic              run_last;

    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (state_reg == S_IN);
    assign accept     = s_tvalid && s_tready;
    assign byte_phase = (state_reg == S_BYTE) || ((state_reg == S_EVAL) && (mode_reg == M_IDLE));

    assign c_letter = is_letter(char_reg);
    assign c_digit  = is_digit(char_reg);
    assign c_space  = is_space(char_reg);

    // keyword prefix tracking for the byte being appended
    assign pos     = byte_phase ? 6'd0 : 6'(len_reg);
    assign kw_base = byte_phase ? 5'h1F : kw_reg;

    always_comb begin
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            kw_step[k] = kw_base[k] && (pos < 6'(kw_len(3'(k)))) &&
                         (kw_char(3'(k), pos) == char_reg);
            kw_done[k] = kw_reg[k] && (6'(len_reg) == 6'(kw_len(3'(k))));
        end
    end

    // first complete keyword wins
    always_comb begin
        kw_found = 1'b0;
        kw_kind  = K_WHILE;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            if (kw_done[k]) begin
                kw_found = 1'b1;
                kw_kind  = 4'(k);
            end
        end
    end

    assign idx_plus = idx_reg + LEN_W'(1);
    assign run_last = (idx_plus == len_reg);

    // sequencer
    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        len_next    = len_reg;
        kw_next     = kw_reg;
        ovf_next    = ovf_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        full_next   = full_reg;
        rkind_next  = rkind_reg;
        req.wr_en   = 1'b0;
        req.rd_en   = 1'b0;
        req.wr_data = char_reg;
        wr_addr     = byte_phase ? '0 : len_reg[ADDR_W-1:0];
        rd_addr     = idx_reg[ADDR_W-1:0];
        emit        = 1'b0;
        e_kind      = K_ERROR;
        e_byte      = 8'd0;
        e_last      = 1'b1;
        e_slot      = '0;
        e_full      = 1'b0;
        e_trunc     = 1'b0;

        if (byte_phase) begin
            // byte taken afresh with no pending token
            mode_next = M_IDLE;
            if (eot_reg || c_space) begin
                state_next = S_IN;
            end else if (c_letter || c_digit) begin
                mode_next   = c_letter ? M_IDENT : M_NUMBER;
                req.wr_en   = 1'b1;
                len_next    = LEN_W'(1);
                kw_next     = kw_step;
                ovf_next    = 1'b0;
                state_next  = S_IN;
            end else if (char_reg == CH_LT) begin
                mode_next  = M_LT;
                state_next = S_IN;
            end else if (char_reg == CH_EQ) begin
                mode_next  = M_EQ;
                state_next = S_IN;
            end else if (out_free) begin
                emit       = 1'b1;
                state_next = S_IN;
                case (char_reg)
                    CH_PLUS:  e_kind = K_PLUS;
                    CH_MINUS: e_kind = K_MINUS;
                    CH_STAR:  e_kind = K_STAR;
                    CH_SEMI:  e_kind = K_SEMI;
                    default: begin
                        e_kind = K_ERROR;
                        e_byte = char_reg;
                    end
                endcase
            end
        end else begin
            unique case (state_reg)
                S_IN: begin
                    if (accept) begin
                        state_next = S_EVAL;
                    end
                end
                S_EVAL: begin
                    if ((mode_reg == M_LT) || (mode_reg == M_EQ)) begin
                        // one-character lookahead on '<' and '='
                        if (out_free) begin
                            emit      = 1'b1;
                            mode_next = M_IDLE;
                            if (!eot_reg && (char_reg == CH_EQ)) begin
                                e_kind     = (mode_reg == M_LT) ? K_LE : K_EQ;
                                state_next = S_IN;
                            end else begin
                                e_kind     = (mode_reg == M_LT) ? K_LT : K_ASSIGN;
                                state_next = S_BYTE;
                            end
                        end
                    end else if (!eot_reg && (c_digit || (c_letter && (mode_reg == M_IDENT))))
                    begin
                        // lexeme continues
                        state_next = S_IN;
                        if (len_reg < LEN_W'(MAX_LEXEME)) begin
                            req.wr_en = 1'b1;
                            len_next  = len_reg + LEN_W'(1);
                            kw_next   = kw_step;
                        end else begin
                            ovf_next = 1'b1;
                            kw_next  = 5'd0;
                        end
                    end else if ((mode_reg == M_IDENT) && !ovf_reg && kw_found) begin
                        // keyword token
                        if (out_free) begin
                            emit       = 1'b1;
                            e_kind     = kw_kind;
                            mode_next  = M_IDLE;
                            state_next = S_BYTE;
                        end
                    end else begin
                        // identifier or number: take a slot and replay the buffer
                        rkind_next = (mode_reg == M_IDENT) ? K_IDENT : K_NUMBER;
                        idx_next   = '0;
                        mode_next  = M_IDLE;
                        state_next = S_RD;
                        if (cnt_reg < SLOT_W'(SYMBOL_SLOTS - 1)) begin
                            slot_next = cnt_reg;
                            cnt_next  = cnt_reg + SLOT_W'(1);
                            full_next = 1'b0;
                        end else begin
                            slot_next = SLOT_W'(SYMBOL_SLOTS - 1);
                            full_next = 1'b1;
                        end
                    end
                end
                S_RD: begin
                    req.rd_en  = 1'b1;
                    state_next = S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        emit     = 1'b1;
                        e_kind   = rkind_reg;
                        e_byte   = rd_data;
                        e_last   = run_last;
                        e_slot   = slot_reg;
                        e_full   = full_reg;
                        e_trunc  = ovf_reg;
                        idx_next = idx_plus;
                        state_next = run_last ? S_BYTE : S_RD;
                    end
                end
                default: begin
                    state_next = S_IN;
                end
            endcase
        end
    end

    // result valid
    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IN;
            mode_reg    <= M_IDLE;
            len_reg     <= '0;
            kw_reg      <= 5'h1F;
            ovf_reg     <= 1'b0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            len_reg     <= len_next;
            kw_reg      <= kw_next;
            ovf_reg     <= ovf_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        slot_reg  <= slot_next;
        full_reg  <= full_next;
        rkind_reg <= rkind_next;
        if (accept) begin
            char_reg <= s_tdata;
            eot_reg  <= s_tlast;
        end
        if (emit) begin
            o_kind_reg  <= e_kind;
            o_byte_reg  <= e_byte;
            o_last_reg  <= e_last;
            o_slot_reg  <= e_slot;
            o_full_reg  <= e_full;
            o_trunc_reg <= e_trunc;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, 6'(o_slot_reg), o_byte_reg};
    assign m_tlast  = o_last_reg;
    assign m_tuser  = {o_trunc_reg, o_full_reg, o_kind_reg};

endmodule
